@@ hw/rtl/h2fp_pkg.sv @@
// ----------------------------------------------------------------------------
// h2fp_pkg
// Shared types, codes and helper functions for the HTTP/2 frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package h2fp_pkg;

  // Frame header length in bytes
  localparam int unsigned HDR_LEN = 9;

  // Default depth of the result buffer (two or more)
  localparam int unsigned RESULT_DEPTH_DEF = 4;

  // Reset value of the maximum payload size register
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd16384;

  // Frame type codes
  localparam logic [7:0] FT_DATA          = 8'h00;
  localparam logic [7:0] FT_HEADERS       = 8'h01;
  localparam logic [7:0] FT_PRIORITY      = 8'h02;
  localparam logic [7:0] FT_RST_STREAM    = 8'h03;
  localparam logic [7:0] FT_SETTINGS      = 8'h04;
  localparam logic [7:0] FT_PUSH_PROMISE  = 8'h05;
  localparam logic [7:0] FT_PING          = 8'h06;
  localparam logic [7:0] FT_GOAWAY        = 8'h07;
  localparam logic [7:0] FT_WINDOW_UPDATE = 8'h08;
  localparam logic [7:0] FT_CONTINUATION  = 8'h09;

  // ACK flag of a SETTINGS frame
  localparam logic [7:0] FLAG_ACK = 8'h01;

  // Summary status codes; stream id checks come before length checks
  typedef enum logic [3:0] {
    ST_OK              = 4'd0,
    ST_SHORT_HEADER    = 4'd1,
    ST_SHORT_PAYLOAD   = 4'd2,
    ST_OVERSIZE        = 4'd3,
    ST_SID_ZERO        = 4'd4,
    ST_SID_NONZERO     = 4'd5,
    ST_SETTINGS_ACK    = 4'd6,
    ST_SETTINGS_LEN    = 4'd7,
    ST_PING_LEN        = 4'd8,
    ST_RST_STREAM_LEN  = 4'd9,
    ST_GOAWAY_LEN      = 4'd10,
    ST_WINUPD_LEN      = 4'd11,
    ST_WINUPD_INCR     = 4'd12
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_of_run;
    status_t     status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] frame_sid;
    logic [23:0] payload_length;
    logic [24:0] bytes_consumed;
  } result_t;

  // Results produced by one byte, zero to two of them
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

  // Residue of a 24-bit value modulo 3 (4 == 1 mod 3, so sum base-4 digits)
  function automatic logic [1:0] mod3_24(input logic [23:0] v);
    logic [3:0] pair [6];
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] u;
    for (int i = 0; i < 6; i++) begin
      pair[i] = 4'(v[4*i +: 2]) + 4'(v[4*i+2 +: 2]);
    end
    s = 6'(pair[0]) + 6'(pair[1]) + 6'(pair[2]) + 6'(pair[3]) + 6'(pair[4]) + 6'(pair[5]);
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // Per-type frame checks; the first failing check wins
  function automatic status_t check_frame(
    input logic [7:0]  ftype,
    input logic [7:0]  flags,
    input logic [23:0] len,
    input logic [30:0] sid,
    input logic        incr_nonzero
  );
    status_t sid_st;
    status_t len_st;
    sid_st = ST_OK;
    len_st = ST_OK;
    case (ftype) inside
      FT_DATA, FT_HEADERS, FT_PRIORITY, FT_RST_STREAM, FT_PUSH_PROMISE,
      FT_CONTINUATION: begin
        if (sid == '0) sid_st = ST_SID_ZERO;
      end
      FT_SETTINGS, FT_PING, FT_GOAWAY: begin
        if (sid != '0) sid_st = ST_SID_NONZERO;
      end
      default: ;
    endcase
    case (ftype)
      FT_SETTINGS: begin
        if (((flags & FLAG_ACK) != '0) && (len != '0)) len_st = ST_SETTINGS_ACK;
        else if (len[0] || (mod3_24(len) != 2'd0)) len_st = ST_SETTINGS_LEN;
      end
      FT_PING: begin
        if (len != 24'd8) len_st = ST_PING_LEN;
      end
      FT_RST_STREAM: begin
        if (len != 24'd4) len_st = ST_RST_STREAM_LEN;
      end
      FT_GOAWAY: begin
        if (len < 24'd8) len_st = ST_GOAWAY_LEN;
      end
      FT_WINDOW_UPDATE: begin
        if (len != 24'd4) len_st = ST_WINUPD_LEN;
        else if (!incr_nonzero) len_st = ST_WINUPD_INCR;
      end
      default: ;
    endcase
    return (sid_st != ST_OK) ? sid_st : len_st;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/h2fp_if.sv @@
// ----------------------------------------------------------------------------
// h2fp_if
// Valid/ready channels of the parser: received bytes in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface h2fp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface h2fp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic        last_of_run;
  logic [3:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [30:0] frame_sid;
  logic [23:0] payload_length;
  logic [24:0] bytes_consumed;

  modport source (
    output valid, output result_kind, output payload_byte, output last_of_run,
    output status, output frame_type, output frame_flags, output frame_sid,
    output payload_length, output bytes_consumed, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input last_of_run,
    input status, input frame_type, input frame_flags, input frame_sid,
    input payload_length, input bytes_consumed, output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/h2fp_parser.sv @@
// ----------------------------------------------------------------------------
// h2fp_parser
// Input register, header/payload state and result formation, one byte a cycle while the result buffer has room.
// ----------------------------------------------------------------------------
`default_nettype none

module h2fp_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  h2fp_byte_if.sink             frame_bytes,
  input  wire logic             cfg_wr_en,
  input  wire logic [23:0]      cfg_wr_data,
  input  wire logic             space_ok,
  output h2fp_pkg::push_t       push
);

  localparam logic [3:0] HDR_END = 4'(h2fp_pkg::HDR_LEN);

  // Input register
  logic        q_valid;
  logic [7:0]  q_byte;
  logic        q_end;

  // Frame state
  logic [23:0] max_payload;
  logic        discarding, discarding_next;
  logic [3:0]  hdr_pos, hdr_pos_next;
  logic [23:0] len, len_next;
  logic [7:0]  ftype, ftype_next;
  logic [7:0]  flags, flags_next;
  logic [30:0] sid, sid_next;
  logic        incr, incr_next;
  logic [23:0] pay_cnt, pay_cnt_next;

  logic        fire;
  logic        in_payload;
  logic        restart;
  logic [7:0]  incr_byte;

  assign fire              = q_valid && space_ok;
  assign frame_bytes.ready = !q_valid || space_ok;
  assign in_payload        = (hdr_pos == HDR_END);

  // Build a summary word; header fields only for a complete frame
  function automatic h2fp_pkg::result_t summary(
    input h2fp_pkg::status_t st,
    input logic              full,
    input logic [7:0]        t,
    input logic [7:0]        f,
    input logic [30:0]       s,
    input logic [23:0]       l
  );
    h2fp_pkg::result_t r;
    r                = '0;
    r.kind           = h2fp_pkg::KIND_SUMMARY;
    r.last_of_run    = 1'b1;
    r.status         = st;
    if (full) begin
      r.frame_type     = t;
      r.frame_flags    = f;
      r.frame_sid      = s;
      r.payload_length = l;
      r.bytes_consumed = {1'b0, l} + 25'(h2fp_pkg::HDR_LEN);
    end
    return r;
  endfunction

  // Hold the byte until the result buffer can take its results
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (frame_bytes.valid && frame_bytes.ready) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_bytes.valid && frame_bytes.ready) begin
      q_byte <= frame_bytes.data_byte;
      q_end  <= frame_bytes.buffer_end;
    end
  end

  // Decode the byte against the frame position
  always_comb begin
    discarding_next = discarding;
    hdr_pos_next    = hdr_pos;
    len_next        = len;
    ftype_next      = ftype;
    flags_next      = flags;
    sid_next        = sid;
    incr_next       = incr;
    pay_cnt_next    = pay_cnt;
    restart         = 1'b0;
    incr_byte       = '0;
    push            = '0;
    if (fire) begin
      if (discarding) begin
        // Drop bytes up to the buffer end
        if (q_end) begin
          discarding_next = 1'b0;
          restart         = 1'b1;
        end
      end else if (!in_payload) begin
        case (hdr_pos) inside
          4'd0, 4'd1, 4'd2: len_next   = {len[15:0], q_byte};
          4'd3:             ftype_next = q_byte;
          4'd4:             flags_next = q_byte;
          4'd5:             sid_next   = {24'd0, q_byte[6:0]};
          default:          sid_next   = {sid[22:0], q_byte};
        endcase
        hdr_pos_next = hdr_pos + 4'd1;
        if (hdr_pos_next != HDR_END) begin
          if (q_end) begin
            push.cnt   = 2'd1;
            push.first = summary(h2fp_pkg::ST_SHORT_HEADER, 1'b0, '0, '0, '0, '0);
            restart    = 1'b1;
          end
        end else if (len_next > max_payload) begin
          push.cnt        = 2'd1;
          push.first      = summary(h2fp_pkg::ST_OVERSIZE, 1'b0, '0, '0, '0, '0);
          restart         = 1'b1;
          discarding_next = !q_end;
        end else if (len_next == '0) begin
          push.cnt   = 2'd1;
          push.first = summary(
            h2fp_pkg::check_frame(ftype_next, flags_next, len_next, sid_next, incr),
            1'b1, ftype_next, flags_next, sid_next, len_next);
          restart    = 1'b1;
        end else if (q_end) begin
          push.cnt   = 2'd1;
          push.first = summary(h2fp_pkg::ST_SHORT_PAYLOAD, 1'b0, '0, '0, '0, '0);
          restart    = 1'b1;
        end
      end else begin
        // Track the window increment over the first four payload bytes
        if (pay_cnt < 24'd4) begin
          incr_byte = (pay_cnt == '0) ? {1'b0, q_byte[6:0]} : q_byte;
          if (incr_byte != '0) incr_next = 1'b1;
        end
        pay_cnt_next              = pay_cnt + 24'd1;
        push.cnt                  = 2'd1;
        push.first.kind           = h2fp_pkg::KIND_PAYLOAD;
        push.first.payload_byte   = q_byte;
        push.first.status         = h2fp_pkg::ST_OK;
        if (pay_cnt_next == len) begin
          push.cnt    = 2'd2;
          push.second = summary(
            h2fp_pkg::check_frame(ftype, flags, len, sid, incr_next),
            1'b1, ftype, flags, sid, len);
          restart     = 1'b1;
        end else if (q_end) begin
          push.cnt    = 2'd2;
          push.second = summary(h2fp_pkg::ST_SHORT_PAYLOAD, 1'b0, '0, '0, '0, '0);
          restart     = 1'b1;
        end else begin
          push.first.last_of_run = 1'b1;
        end
      end
    end
    // Clear the frame and wait for the next header
    if (restart) begin
      hdr_pos_next = '0;
      len_next     = '0;
      ftype_next   = '0;
      flags_next   = '0;
      sid_next     = '0;
      incr_next    = 1'b0;
      pay_cnt_next = '0;
    end
  end

  // Advance the frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= h2fp_pkg::MAX_PAYLOAD_RST;
      discarding  <= 1'b0;
      hdr_pos     <= '0;
      len         <= '0;
      ftype       <= '0;
      flags       <= '0;
      sid         <= '0;
      incr        <= 1'b0;
      pay_cnt     <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_payload <= cfg_wr_data;
      end
      discarding <= discarding_next;
      hdr_pos    <= hdr_pos_next;
      len        <= len_next;
      ftype      <= ftype_next;
      flags      <= flags_next;
      sid        <= sid_next;
      incr       <= incr_next;
      pay_cnt    <= pay_cnt_next;
    end
  end

  // Discard mode always sits at a cleared frame
  a_discard_clear: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (hdr_pos == '0) && (len == '0) && (pay_cnt == '0))
    else $error("discard mode with frame state left over");

  // Payload count stays inside the declared length
  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (len != '0) && (pay_cnt < len))
    else $error("payload count past frame length");

  // No payload count while the header is collected
  a_header_no_count: assert property (@(posedge clk) disable iff (rst)
    !in_payload |-> (pay_cnt == '0) && (hdr_pos < HDR_END))
    else $error("header position or payload count out of step");

endmodule

`default_nettype wire

@@ hw/rtl/h2fp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// h2fp_result_fifo
// Small result buffer: takes up to two words a cycle while it has room for two, hands one out a cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module h2fp_result_fifo #(
  parameter int unsigned DEPTH = h2fp_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire h2fp_pkg::push_t  push,
  output logic                  space_ok,
  h2fp_result_if.source         results
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  h2fp_pkg::result_t mem [DEPTH];
  h2fp_pkg::result_t head;
  logic [PW-1:0]     wr_ptr, wr_ptr_next, wr_ptr1;
  logic [PW-1:0]     rd_ptr, rd_ptr_next;
  logic [CW-1:0]     count, count_next;
  logic              pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1  = ptr_inc(wr_ptr);
  assign pop      = results.valid && results.ready;
  assign space_ok = (count <= CW'(DEPTH - 2));

  // Advance pointers and fill count
  always_comb begin
    case (push.cnt)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.second;
    end
  end

  // Drive the head word
  assign head                   = mem[rd_ptr];
  assign results.valid          = (count != '0);
  assign results.result_kind    = head.kind;
  assign results.payload_byte   = head.payload_byte;
  assign results.last_of_run    = head.last_of_run;
  assign results.status         = head.status;
  assign results.frame_type     = head.frame_type;
  assign results.frame_flags    = head.frame_flags;
  assign results.frame_sid      = head.frame_sid;
  assign results.payload_length = head.payload_length;
  assign results.bytes_consumed = head.bytes_consumed;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result buffer overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> space_ok && (push.cnt != 2'd3))
    else $error("words pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd0) && !pop |=> $stable(count))
    else $error("fill count moved without traffic");

endmodule

`default_nettype wire

@@ hw/rtl/http2_frame_parser_validator_top.sv @@
// ----------------------------------------------------------------------------
// http2_frame_parser_validator_top
// HTTP/2 frame header parser and validator, one received byte per word.
// ----------------------------------------------------------------------------
// Path: the first result word of a byte goes through the input register, then
//   the result buffer, and waits in the input register while the buffer is full.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the result side takes a word every cycle; a byte that gives a payload word
//   and a summary puts two words into the result buffer.
// Reset: synchronous rst clears the frame state, discard mode and the result
//   buffer, and sets max_payload_size to 16384.
`default_nettype none

module http2_frame_parser_validator_top #(
  parameter int unsigned RESULT_DEPTH = h2fp_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  h2fp_byte_if.sink        frame_bytes,
  h2fp_result_if.source    results,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data
);

  h2fp_pkg::push_t push;
  logic            space_ok;

  // Parse bytes into result words
  h2fp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .space_ok    (space_ok),
    .push        (push)
  );

  // Buffer words toward the result channel
  h2fp_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .results  (results)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives HTTP/2 byte streams into the frame parser and checks every result
// word against a cycle-free model of the header parser and frame validator.
// A short table of directed bytes runs first, then random frames under
// several max_payload_size settings, with random stalls on both channels outside the second phase.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned PHASE_BYTES  = 125;
  localparam int unsigned SETTLE_TICKS = 4;

  // One row of the directed byte table; a flagged row sets the expected summary status
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              has_status;
    h2fp_pkg::status_t status;
  } stim_row_t;

  localparam int unsigned DIR_N = 30;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // Buffer ends on the first header byte
    '{8'hFF, 1'b1, 1'b1, h2fp_pkg::ST_SHORT_HEADER},
    // All-ones header: maximum length, unknown type, reserved sid bit set
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b1, h2fp_pkg::ST_OVERSIZE},
    // Dropped up to and including the buffer end
    '{8'h00, 1'b1, 1'b0, h2fp_pkg::ST_OK},
    // Empty SETTINGS ack that ends exactly at the buffer end
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{h2fp_pkg::FT_SETTINGS, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{h2fp_pkg::FLAG_ACK, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, h2fp_pkg::ST_OK},
    // DATA frame of two bytes cut after its first payload byte
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h02, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{h2fp_pkg::FT_DATA, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'h01, 1'b0, 1'b0, h2fp_pkg::ST_OK},
    '{8'hAA, 1'b1, 1'b1, h2fp_pkg::ST_SHORT_PAYLOAD}
  };

  localparam logic [23:0] MAX_STEPS [PHASE_COUNT] = '{
    h2fp_pkg::MAX_PAYLOAD_RST, 24'hFFFFFF, 24'd0, 24'd10, 24'd0, h2fp_pkg::MAX_PAYLOAD_RST
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  h2fp_byte_if   byte_ch ();
  h2fp_result_if result_ch ();

  http2_frame_parser_validator_top dut (
    .clk        (clk),
    .rst        (rst),
    .frame_bytes(byte_ch),
    .results    (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Parser model state
  logic [23:0] max_len;
  logic [24:0] frame_pos;
  logic [23:0] hdr_len;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_flags;
  logic [30:0] hdr_sid;
  logic        incr_seen;
  logic        discarding;

  h2fp_pkg::result_t frame_results_q [$];
  int                fail_cnt = 0;
  int                idle_pct = 30;
  int unsigned       phase_bytes = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Append one expected word to the tail of the queue
  task automatic queue_word(input h2fp_pkg::result_t w);
    frame_results_q = {frame_results_q, w};
  endtask

  task automatic clear_frame();
    frame_pos = '0;
    hdr_len   = '0;
    hdr_type  = '0;
    hdr_flags = '0;
    hdr_sid   = '0;
    incr_seen = 1'b0;
  endtask

  // Validation of a complete frame; the first failing rule wins
  function automatic h2fp_pkg::status_t frame_verdict();
    logic stream_frame;
    logic conn_frame;
    stream_frame = hdr_type inside {h2fp_pkg::FT_DATA, h2fp_pkg::FT_HEADERS,
                                    h2fp_pkg::FT_PRIORITY, h2fp_pkg::FT_RST_STREAM,
                                    h2fp_pkg::FT_PUSH_PROMISE, h2fp_pkg::FT_CONTINUATION};
    conn_frame   = hdr_type inside {h2fp_pkg::FT_SETTINGS, h2fp_pkg::FT_PING,
                                    h2fp_pkg::FT_GOAWAY};
    if (stream_frame && hdr_sid == '0) return h2fp_pkg::ST_SID_ZERO;
    if (conn_frame && hdr_sid != '0) return h2fp_pkg::ST_SID_NONZERO;
    case (hdr_type)
      h2fp_pkg::FT_SETTINGS: begin
        if ((hdr_flags & h2fp_pkg::FLAG_ACK) != '0 && hdr_len != '0) begin
          return h2fp_pkg::ST_SETTINGS_ACK;
        end
        if (hdr_len % 6 != 0) return h2fp_pkg::ST_SETTINGS_LEN;
      end
      h2fp_pkg::FT_PING: begin
        if (hdr_len != 24'd8) return h2fp_pkg::ST_PING_LEN;
      end
      h2fp_pkg::FT_RST_STREAM: begin
        if (hdr_len != 24'd4) return h2fp_pkg::ST_RST_STREAM_LEN;
      end
      h2fp_pkg::FT_GOAWAY: begin
        if (hdr_len < 24'd8) return h2fp_pkg::ST_GOAWAY_LEN;
      end
      h2fp_pkg::FT_WINDOW_UPDATE: begin
        if (hdr_len != 24'd4) return h2fp_pkg::ST_WINUPD_LEN;
        if (!incr_seen) return h2fp_pkg::ST_WINUPD_INCR;
      end
      default: ;
    endcase
    return h2fp_pkg::ST_OK;
  endfunction

  function automatic h2fp_pkg::result_t make_word(h2fp_pkg::kind_t k, logic [7:0] pb,
                                                  h2fp_pkg::status_t st, logic full);
    h2fp_pkg::result_t w;
    w = '0;
    w.kind = k;
    w.payload_byte = pb;
    w.status = st;
    if (full) begin
      w.frame_type     = hdr_type;
      w.frame_flags    = hdr_flags;
      w.frame_sid      = hdr_sid;
      w.payload_length = hdr_len;
      w.bytes_consumed = 25'(hdr_len) + 25'(h2fp_pkg::HDR_LEN);
    end
    return w;
  endfunction

  // Advance the model by one accepted byte and queue the words it yields
  task automatic parse_byte(input logic [7:0] b, input logic e);
    int unsigned idx;
    int          n0;
    n0 = frame_results_q.size();
    if (discarding) begin
      if (e) begin
        discarding = 1'b0;
        clear_frame();
      end
      return;
    end
    if (frame_pos < h2fp_pkg::HDR_LEN) begin
      case (frame_pos)
        25'd0, 25'd1, 25'd2: hdr_len = {hdr_len[15:0], b};
        25'd3:               hdr_type = b;
        25'd4:               hdr_flags = b;
        25'd5:               hdr_sid = {24'd0, b[6:0]};
        default:             hdr_sid = {hdr_sid[22:0], b};
      endcase
      frame_pos = frame_pos + 25'd1;
      if (frame_pos < h2fp_pkg::HDR_LEN) begin
        if (e) begin
          queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, h2fp_pkg::ST_SHORT_HEADER, 1'b0));
          clear_frame();
        end
      end else if (hdr_len > max_len) begin
        queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, h2fp_pkg::ST_OVERSIZE, 1'b0));
        clear_frame();
        if (!e) discarding = 1'b1;
      end else if (hdr_len == '0) begin
        queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, frame_verdict(), 1'b1));
        clear_frame();
      end else if (e) begin
        queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, h2fp_pkg::ST_SHORT_PAYLOAD, 1'b0));
        clear_frame();
      end
    end else begin
      // The first four payload bytes carry the window increment
      idx = 32'(frame_pos) - h2fp_pkg::HDR_LEN;
      if (idx < 4 && ((idx == 0) ? (b[6:0] != '0) : (b != '0))) incr_seen = 1'b1;
      queue_word(make_word(h2fp_pkg::KIND_PAYLOAD, b, h2fp_pkg::ST_OK, 1'b0));
      frame_pos = frame_pos + 25'd1;
      if (32'(frame_pos) - h2fp_pkg::HDR_LEN >= 32'(hdr_len)) begin
        queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, frame_verdict(), 1'b1));
        clear_frame();
      end else if (e) begin
        queue_word(make_word(h2fp_pkg::KIND_SUMMARY, 8'd0, h2fp_pkg::ST_SHORT_PAYLOAD, 1'b0));
        clear_frame();
      end
    end
    if (frame_results_q.size() > n0) frame_results_q[$].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Byte channel driver
  // ---------------------------------------------------------------------------

  // Present one word and hold it until accepted; valid stays high on return
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.buffer_end <= e;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    phase_bytes++;
    parse_byte(b, e);
  endtask

  // Hold the sender until every queued word has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_max(input logic [23:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len = v;
  endtask

  // A few random bytes closed by a buffer end; resyncs as a short header
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // One frame with random content, sometimes cut short or oversized
  task automatic send_frame();
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [23:0] len;
    logic [30:0] sid;
    logic [7:0]  hdr [9];
    logic [7:0]  b;
    logic        oversize;
    logic        zero_incr;
    logic        endbit;
    int          sel;
    int          total;
    int          last_i;
    int          n;

    sel = $urandom_range(0, 11);
    ftype = (sel < 10) ? 8'(sel) : 8'($urandom_range(10, 255));
    flags = 8'($urandom_range(0, 255));
    sid = ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom);
    zero_incr = ($urandom_range(0, 3) == 0);

    // Pick a length: mostly what the type wants, sometimes off or oversize
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      case (ftype)
        h2fp_pkg::FT_SETTINGS:   len = 24'(6 * $urandom_range(0, 3));
        h2fp_pkg::FT_PING:       len = 24'd8;
        h2fp_pkg::FT_RST_STREAM,
        h2fp_pkg::FT_WINDOW_UPDATE: len = 24'd4;
        h2fp_pkg::FT_GOAWAY:     len = 24'($urandom_range(8, 16));
        default:                 len = 24'($urandom_range(0, 12));
      endcase
    end else if (sel < 85) begin
      len = 24'($urandom_range(0, 20));
    end else if (sel < 92 && max_len <= 24'd40) begin
      len = max_len;
    end else if (sel >= 92 && max_len != 24'hFFFFFF) begin
      len = 24'($urandom_range(32'(max_len) + 1, 32'hFFFFFF));
    end else begin
      len = 24'($urandom_range(0, 3));
    end
    oversize = (len > max_len);

    hdr[0] = len[23:16];
    hdr[1] = len[15:8];
    hdr[2] = len[7:0];
    hdr[3] = ftype;
    hdr[4] = flags;
    hdr[5] = {1'($urandom_range(0, 1)), sid[30:24]};
    hdr[6] = sid[23:16];
    hdr[7] = sid[15:8];
    hdr[8] = sid[7:0];

    total  = oversize ? 9 : 9 + int'(len);
    endbit = ($urandom_range(0, 9) < 3);
    last_i = total - 1;
    if ($urandom_range(0, 9) == 0) begin
      last_i = $urandom_range(0, total - 1);
      endbit = 1'b1;
    end

    for (int i = 0; i <= last_i; i++) begin
      if (i < 9) begin
        b = hdr[i];
      end else if (ftype == h2fp_pkg::FT_WINDOW_UPDATE && zero_incr && i < 13) begin
        b = (i == 9) ? {1'($urandom_range(0, 1)), 7'd0} : 8'd0;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b, (i == last_i) ? endbit : 1'b0);
    end

    // Oversize without buffer end: feed the dropped tail up to a buffer end
    if (oversize && last_i == 8 && !endbit) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i <= n; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == n);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random ready, word checks
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string fname, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_word();
    h2fp_pkg::result_t w;
    if (frame_results_q.size() == 0) begin
      $display("%0t: result word mismatch: expected none, actual kind %0d, status %0d",
               $time, result_ch.result_kind, result_ch.status);
      fail_cnt++;
    end else begin
      w = frame_results_q.pop_front();
      cmp_field("result_kind", w.kind, result_ch.result_kind);
      cmp_field("payload_byte", w.payload_byte, result_ch.payload_byte);
      cmp_field("last_of_run", w.last_of_run, result_ch.last_of_run);
      cmp_field("status", w.status, result_ch.status);
      cmp_field("frame_type", w.frame_type, result_ch.frame_type);
      cmp_field("frame_flags", w.frame_flags, result_ch.frame_flags);
      cmp_field("frame_sid", w.frame_sid, result_ch.frame_sid);
      cmp_field("payload_length", w.payload_length, result_ch.payload_length);
      cmp_field("bytes_consumed", w.bytes_consumed, result_ch.bytes_consumed);
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_word();
      result_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("http2_frame_parser_validator_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [23:0] step_max;

    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= '0;
    byte_ch.buffer_end <= 1'b0;
    max_len    = h2fp_pkg::MAX_PAYLOAD_RST;
    discarding = 1'b0;
    clear_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset maximum
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last);
      if (DIR_ROWS[i].has_status) begin
        if (frame_results_q.size() == 0 ||
            frame_results_q[$].kind != h2fp_pkg::KIND_SUMMARY) begin
          $display("%0t: table row %0d gives no summary word", $time, i);
          fail_cnt++;
        end else begin
          frame_results_q[$].status = DIR_ROWS[i].status;
        end
      end
    end

    // Random frames over several maximum payload settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        drain();
        step_max = (ph == 4) ? 24'($urandom_range(1, 40)) : MAX_STEPS[ph];
        write_max(step_max);
      end
      idle_pct = (ph == 1) ? 0 : 30;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
        end else begin
          send_frame();
        end
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("http2_frame_parser_validator_top test passed");
    end else begin
      $display("http2_frame_parser_validator_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/h2fp_pkg.sv
hw/rtl/h2fp_if.sv
hw/rtl/h2fp_parser.sv
hw/rtl/h2fp_result_fifo.sv
hw/rtl/http2_frame_parser_validator_top.sv
test/testbench.sv
